### sv/text_line_number_escape_filter_assert.svh
// ----------------------------------------------------------------------------
// text_line_number_escape_filter_assert.svh
// assertion macros shared by the line numbering and escape filter
// ----------------------------------------------------------------------------
`ifndef TEXT_LINE_NUMBER_ESCAPE_FILTER_ASSERT_SVH
`define TEXT_LINE_NUMBER_ESCAPE_FILTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TLNEF_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define TLNEF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/tlnef_pkg.sv
// ----------------------------------------------------------------------------
// tlnef_pkg
// shared types and character constants of the line numbering escape filter
// ----------------------------------------------------------------------------
package tlnef_pkg;

  // input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_word_t;

  // option registers
  typedef struct packed {
    logic number_all_lines;
    logic number_nonblank_lines;
    logic squeeze_blank_lines;
    logic show_line_ends;
    logic show_tab_chars;
    logic show_nonprinting;
  } cfg_t;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] CFG_NUMBER_ALL      = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_NUMBER_NONBLANK = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SQUEEZE_BLANK   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_SHOW_ENDS       = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_SHOW_TABS       = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_SHOW_NONPRINT   = 3'd5;

  // marker bytes placed before the final byte
  typedef enum logic [1:0] {
    MARK_NONE,
    MARK_CARET,
    MARK_DOLLAR,
    MARK_META
  } mark_e;

  // per-word control handed from front to back
  typedef struct packed {
    logic       pfx_en;
    mark_e      mark;
    logic [7:0] fin_byte;
  } desc_ctl_t;

  // back-end status seen by the top level
  typedef struct packed {
    logic q_pop;
    logic mid_item;
  } bk_stat_t;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [3:0] CH_DIGIT_HI = 4'h3;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] ESC_OFFSET = 8'd64;
  localparam logic [7:0] CTL_LIMIT  = 8'd32;
  localparam logic [1:0] BLANK_SAT  = 2'd2;

endpackage

### sv/text_line_number_escape_filter.sv
// ----------------------------------------------------------------------------
// text_line_number_escape_filter
// byte stream filter: line numbers, blank squeezing, visible ends, tabs and
// control bytes
// ----------------------------------------------------------------------------
//  channel   handshake         payload
//  input     push / full       in_i  (data_byte, file_start)
//  result    empty / pop       out_o (out_byte, last_of_run)
//  config    cfg_we_i          cfg_addr_i, cfg_wdata_i
//
//  one input word accepted per cycle while the descriptor queue has room
//  a word yields 0 to NUMBER_DIGITS+5 bytes; the back part emits one byte per
//  cycle unless the result stalls, and keeps a word's descriptor at the head until its last byte
//  first byte of a word passes through the descriptor queue, then the result register
//  reset clears the per-file state and options at once, no clearing pass
//  result stalls fill the queue and then raise full
// ----------------------------------------------------------------------------
`include "text_line_number_escape_filter_assert.svh"

module text_line_number_escape_filter import tlnef_pkg::*; #(
  parameter int unsigned NUMBER_DIGITS = 6,
  parameter int unsigned QUEUE_DEPTH   = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input side
  input  logic                  push,
  output logic                  full,
  input  in_word_t              in_i,
  // result side
  output logic                  empty,
  input  logic                  pop,
  output out_word_t             out_o,
  // option writes
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic                  cfg_wdata_i
);

  // descriptor layout in the queue: control, digits, blank mask
  localparam int unsigned CTL_W  = $bits(desc_ctl_t);
  localparam int unsigned DESC_W = CTL_W + 5 * NUMBER_DIGITS;

  cfg_t                          cfg_q;
  logic                          acc, q_push, q_empty, q_full;
  desc_ctl_t                     fr_ctl, hd_ctl;
  logic [NUMBER_DIGITS-1:0][3:0] fr_digits, hd_digits;
  logic [NUMBER_DIGITS-1:0]      fr_blank, hd_blank;
  logic [DESC_W-1:0]             q_wdata, q_rdata;
  bk_stat_t                      stat;

  // option registers, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_NUMBER_ALL:      cfg_q.number_all_lines      <= cfg_wdata_i;
        CFG_NUMBER_NONBLANK: cfg_q.number_nonblank_lines <= cfg_wdata_i;
        CFG_SQUEEZE_BLANK:   cfg_q.squeeze_blank_lines   <= cfg_wdata_i;
        CFG_SHOW_ENDS:       cfg_q.show_line_ends        <= cfg_wdata_i;
        CFG_SHOW_TABS:       cfg_q.show_tab_chars        <= cfg_wdata_i;
        CFG_SHOW_NONPRINT:   cfg_q.show_nonprinting      <= cfg_wdata_i;
        default:             cfg_q <= cfg_q;
      endcase
    end
  end

  // a word is taken whenever the queue has room; squeezed words vanish in the front
  assign full = q_full;
  assign acc  = push && !q_full;

  tlnef_front #(
    .NUMBER_DIGITS (NUMBER_DIGITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .acc_i    (acc),
    .in_i     (in_i),
    .wr_o     (q_push),
    .ctl_o    (fr_ctl),
    .digits_o (fr_digits),
    .blank_o  (fr_blank)
  );

  assign q_wdata = {fr_ctl, fr_digits, fr_blank};

  tlnef_queue #(
    .WIDTH (DESC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (stat.q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // unpack the head descriptor
  assign hd_ctl    = q_rdata[DESC_W-1 -: CTL_W];
  assign hd_digits = q_rdata[5*NUMBER_DIGITS-1 -: 4*NUMBER_DIGITS];
  assign hd_blank  = q_rdata[NUMBER_DIGITS-1:0];

  // back part walks the head and owns the result register
  tlnef_back #(
    .NUMBER_DIGITS (NUMBER_DIGITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_vld_i    (!q_empty),
    .head_ctl_i    (hd_ctl),
    .head_digits_i (hd_digits),
    .head_blank_i  (hd_blank),
    .pop_i         (pop),
    .empty_o       (empty),
    .out_o         (out_o),
    .stat_o        (stat)
  );

  // queue is only popped with a descriptor at its head
  `TLNEF_ASSERT_IMPL(a_pop_has_head, clk_i, rst_ni, stat.q_pop, !q_empty, "pop of empty queue")
  // a word part-way through expansion keeps its descriptor at the head
  `TLNEF_ASSERT_IMPL(a_mid_has_head, clk_i, rst_ni, stat.mid_item, !q_empty, "head lost mid word")
  // front never writes a full queue
  `TLNEF_ASSERT_IMPL(a_push_room, clk_i, rst_ni, q_push, !q_full, "push into full queue")
  // a write into an empty queue is seen at the head next cycle
  `TLNEF_ASSERT_NEXT(a_push_lands, clk_i, rst_ni, q_push && q_empty, !q_empty, "pushed word lost")

endmodule

### sv/tlnef_front.sv
// ----------------------------------------------------------------------------
// tlnef_front
// classifies each input word, keeps the per-file state, builds a descriptor
// ----------------------------------------------------------------------------
module tlnef_front import tlnef_pkg::*; #(
  parameter int unsigned NUMBER_DIGITS = 6
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cfg_t                            cfg_i,
  input  logic                            acc_i,
  input  in_word_t                        in_i,
  output logic                            wr_o,
  output desc_ctl_t                       ctl_o,
  output logic [NUMBER_DIGITS-1:0][3:0]   digits_o,
  output logic [NUMBER_DIGITS-1:0]        blank_o
);

  localparam int unsigned CNT_W = 4 * NUMBER_DIGITS;

  typedef logic [NUMBER_DIGITS-1:0][3:0] bcd_t;

  localparam bcd_t CNT_ONE = bcd_t'(CNT_W'(1));

  bcd_t       cnt_q, cnt_d, eff_cnt, cnt_inc;
  logic       ls_q, ls_d, eff_ls;
  logic [1:0] blank_q, blank_d, eff_blank, blank_new;
  logic       is_lf, drop, num_all, pfx_num, pfx_sp, tab_sub;
  logic       is_meta, is_ctl, is_del;
  logic [7:0] c1, fin;
  logic [NUMBER_DIGITS-1:0] blank_num;

  // file start restarts the per-file state ahead of this word
  assign eff_cnt   = in_i.file_start ? CNT_ONE : cnt_q;
  assign eff_ls    = in_i.file_start ? 1'b1 : ls_q;
  assign eff_blank = in_i.file_start ? 2'd0 : blank_q;

  assign is_lf   = (in_i.data_byte == CH_LF);
  assign num_all = cfg_i.number_all_lines && !cfg_i.number_nonblank_lines;

  always_comb begin
    blank_new = 2'd0;
    drop      = 1'b0;
    if (cfg_i.squeeze_blank_lines && is_lf && eff_ls) begin
      blank_new = (eff_blank < BLANK_SAT) ? eff_blank + 2'd1 : eff_blank;
      drop      = (blank_new == BLANK_SAT);
    end
  end

  assign pfx_num = eff_ls && ((cfg_i.number_nonblank_lines && !is_lf) || num_all);
  assign pfx_sp  = is_lf && cfg_i.show_line_ends && cfg_i.number_nonblank_lines && eff_ls;
  assign tab_sub = (in_i.data_byte == CH_TAB) && cfg_i.show_tab_chars;
  assign c1      = tab_sub ? CH_I : in_i.data_byte;

  assign is_meta = cfg_i.show_nonprinting && (c1[7:5] == 3'b100);
  assign is_ctl  = cfg_i.show_nonprinting && (c1 < CTL_LIMIT) && (c1 != CH_LF) &&
                   (c1 != CH_TAB);
  assign is_del  = cfg_i.show_nonprinting && (c1 == CH_DEL);

  always_comb begin
    if (is_meta || is_del) begin
      fin = c1 - ESC_OFFSET;
    end else if (is_ctl) begin
      fin = c1 + ESC_OFFSET;
    end else begin
      fin = c1;
    end
  end

  always_comb begin
    ctl_o.pfx_en   = pfx_num || pfx_sp;
    ctl_o.fin_byte = fin;
    priority if (tab_sub) begin
      ctl_o.mark = MARK_CARET;
    end else if (is_lf && cfg_i.show_line_ends) begin
      ctl_o.mark = MARK_DOLLAR;
    end else if (is_meta) begin
      ctl_o.mark = MARK_META;
    end else if (is_ctl || is_del) begin
      ctl_o.mark = MARK_CARET;
    end else begin
      ctl_o.mark = MARK_NONE;
    end
  end

  // saturating bcd increment
  always_comb begin
    logic carry;
    logic all9;
    carry = 1'b1;
    all9  = 1'b1;
    for (int i = 0; i < int'(NUMBER_DIGITS); i++) begin
      if (eff_cnt[i] != 4'd9) all9 = 1'b0;
    end
    for (int i = 0; i < int'(NUMBER_DIGITS); i++) begin
      if (carry) begin
        if (eff_cnt[i] == 4'd9) begin
          cnt_inc[i] = 4'd0;
        end else begin
          cnt_inc[i] = eff_cnt[i] + 4'd1;
          carry      = 1'b0;
        end
      end else begin
        cnt_inc[i] = eff_cnt[i];
      end
    end
    if (all9) cnt_inc = eff_cnt;
  end

  // leading zeros print as spaces, lowest digit always shown
  always_comb begin
    logic hi_zero;
    hi_zero = 1'b1;
    for (int i = int'(NUMBER_DIGITS) - 1; i >= 0; i--) begin
      hi_zero      = hi_zero && (eff_cnt[i] == 4'd0);
      blank_num[i] = hi_zero && (i > 0);
    end
  end

  assign digits_o = eff_cnt;
  assign blank_o  = pfx_sp ? '1 : blank_num;
  assign wr_o     = acc_i && !drop;

  always_comb begin
    cnt_d   = cnt_q;
    ls_d    = ls_q;
    blank_d = blank_q;
    if (acc_i) begin
      cnt_d   = (pfx_num && !drop) ? cnt_inc : eff_cnt;
      ls_d    = drop ? eff_ls : (fin == CH_LF);
      blank_d = blank_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= CNT_ONE;
      ls_q    <= 1'b1;
      blank_q <= 2'd0;
    end else begin
      cnt_q   <= cnt_d;
      ls_q    <= ls_d;
      blank_q <= blank_d;
    end
  end

endmodule

### sv/tlnef_queue.sv
// ----------------------------------------------------------------------------
// tlnef_queue
// short descriptor queue between the front and back parts
// ----------------------------------------------------------------------------
module tlnef_queue import tlnef_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;

  assign rdata_o = mem[rd_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(DEPTH));

  always_ff @(posedge clk_i) begin
    if (push_i) mem[wr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + AW'(1);
      if (pop_i)  rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + AW'(1);
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CW'(1);
        2'b01:   cnt_q <= cnt_q - CW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### sv/tlnef_back.sv
// ----------------------------------------------------------------------------
// tlnef_back
// expands a descriptor into bytes, one per cycle unless the result stalls
// ----------------------------------------------------------------------------
module tlnef_back import tlnef_pkg::*; #(
  parameter int unsigned NUMBER_DIGITS = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          head_vld_i,
  input  desc_ctl_t                     head_ctl_i,
  input  logic [NUMBER_DIGITS-1:0][3:0] head_digits_i,
  input  logic [NUMBER_DIGITS-1:0]      head_blank_i,
  input  logic                          pop_i,
  output logic                          empty_o,
  output out_word_t                     out_o,
  output bk_stat_t                      stat_o
);

  // slots: digits, tab, three marker places, final byte
  localparam int unsigned SLOT_W = $clog2(NUMBER_DIGITS + 5);
  localparam int unsigned DIG_IW = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;
  localparam logic [SLOT_W-1:0] S_TAB  = SLOT_W'(NUMBER_DIGITS);
  localparam logic [SLOT_W-1:0] S_M    = SLOT_W'(NUMBER_DIGITS + 1);
  localparam logic [SLOT_W-1:0] S_DASH = SLOT_W'(NUMBER_DIGITS + 2);
  localparam logic [SLOT_W-1:0] S_MARK = SLOT_W'(NUMBER_DIGITS + 3);
  localparam logic [SLOT_W-1:0] S_FIN  = SLOT_W'(NUMBER_DIGITS + 4);
  localparam logic [SLOT_W-1:0] S_TOP  = SLOT_W'(NUMBER_DIGITS - 1);

  logic              out_vld_q, fresh_q;
  logic [SLOT_W-1:0] pos_q, after_pfx, start, cur, nxt, dig_sel;
  logic [DIG_IW-1:0] dig_idx;
  logic              emit, last;
  logic [7:0]        byte_val;
  out_word_t         out_q;

  always_comb begin
    if (head_ctl_i.mark == MARK_META) begin
      after_pfx = S_M;
    end else if (head_ctl_i.mark != MARK_NONE) begin
      after_pfx = S_MARK;
    end else begin
      after_pfx = S_FIN;
    end
  end

  assign start   = head_ctl_i.pfx_en ? '0 : after_pfx;
  assign cur     = fresh_q ? start : pos_q;
  assign nxt     = (cur == S_TAB) ? after_pfx : cur + SLOT_W'(1);
  assign dig_sel = S_TOP - cur;
  assign dig_idx = dig_sel[DIG_IW-1:0];
  assign last    = (cur == S_FIN);
  assign emit    = head_vld_i && (!out_vld_q || pop_i);

  always_comb begin
    priority if (cur < S_TAB) begin
      byte_val = head_blank_i[dig_idx] ? CH_SPACE : {CH_DIGIT_HI, head_digits_i[dig_idx]};
    end else if (cur == S_TAB) begin
      byte_val = CH_TAB;
    end else if (cur == S_M) begin
      byte_val = CH_M;
    end else if (cur == S_DASH) begin
      byte_val = CH_DASH;
    end else if (cur == S_MARK) begin
      byte_val = (head_ctl_i.mark == MARK_DOLLAR) ? CH_DOLLAR : CH_CARET;
    end else begin
      byte_val = head_ctl_i.fin_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      fresh_q   <= 1'b1;
      pos_q     <= '0;
    end else if (emit) begin
      out_vld_q <= 1'b1;
      if (last) begin
        fresh_q <= 1'b1;
      end else begin
        fresh_q <= 1'b0;
        pos_q   <= nxt;
      end
    end else if (pop_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.out_byte    <= byte_val;
      out_q.last_of_run <= last;
    end
  end

  assign out_o           = out_q;
  assign empty_o         = !out_vld_q;
  assign stat_o.q_pop    = emit && last;
  assign stat_o.mid_item = !fresh_q;

endmodule
